// File: hdl/cjd_pkg.sv
// ---------------------------------------------------------------------------
// cjd_pkg: shared definitions for the circular job deque
// Sizes, command and status codes, controller/datapath interface structs
// and the circular slot helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package cjd_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MODE_W  = 3;
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = ID_W + PRIO_W;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // Read source: first walk slot (head), next walk slot, pop at either end
    typedef enum logic [1:0] {
        RD_WALK_FIRST,
        RD_WALK_NEXT,
        RD_POP_FRONT,
        RD_POP_REAR
    } cjd_rd_sel_t;

    typedef struct packed {
        logic                capture;
        logic                push_front;
        logic                push_rear;
        logic                rd_en;
        cjd_rd_sel_t         rd_sel;
        logic                out_load;
        logic [STAT_W-1:0]   out_status;
        logic                out_use_ram;
        logic                out_last;
    } cjd_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                full;
        logic                empty;
        logic                match;
        logic                rem_zero;
    } cjd_stat_t;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cjd_ram.sv
// ---------------------------------------------------------------------------
// cjd_ram: generic simple dual-port RAM
// One write port, one read port with read enable and registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module cjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [ADDR_W-1:0]          waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [ADDR_W-1:0]          raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/cjd_datapath.sv
// ---------------------------------------------------------------------------
// cjd_datapath: deque storage, pointers and result register
// Holds head, tail and count, the walk pointer for search and list, the
// entry RAM and the registered result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module cjd_datapath import cjd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cjd_cmd_t               cmd,
    output cjd_stat_t                   stat,
    input  wire logic [MODE_W-1:0]      s_mode,
    input  wire logic [ID_W-1:0]        s_job_id,
    input  wire logic [PRIO_W-1:0]      s_job_priority,
    output logic      [STAT_W-1:0]      m_status,
    output logic      [ID_W-1:0]        m_out_job_id,
    output logic      [PRIO_W-1:0]      m_out_priority,
    output logic                        m_last
);

    logic [MODE_W-1:0]  mode_reg;
    logic [ID_W-1:0]    key_reg;
    logic [PRIO_W-1:0]  prio_reg;

    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   walk_reg, walk_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;

    logic [STAT_W-1:0]  status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [PRIO_W-1:0]  out_prio_reg;
    logic               last_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ID_W-1:0]    rd_id;
    logic [PRIO_W-1:0]  rd_prio;

    assign ram_we    = cmd.push_front | cmd.push_rear;
    assign ram_waddr = cmd.push_front ? prev_slot(head_reg) : tail_reg;
    assign rd_id     = ram_rdata[ENTRY_W-1:PRIO_W];
    assign rd_prio   = ram_rdata[PRIO_W-1:0];

    always_comb begin
        case (cmd.rd_sel)
            RD_WALK_FIRST: ram_raddr = head_reg;
            RD_WALK_NEXT:  ram_raddr = walk_reg;
            RD_POP_FRONT:  ram_raddr = head_reg;
            RD_POP_REAR:   ram_raddr = prev_slot(tail_reg);
            default:       ram_raddr = walk_reg;
        endcase
    end

    cjd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg, prio_reg}),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        rem_next   = rem_reg;
        if (cmd.push_front) begin
            head_next  = prev_slot(head_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.push_rear) begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.rd_en) begin
            case (cmd.rd_sel)
                RD_WALK_FIRST: begin
                    walk_next = next_slot(head_reg);
                    rem_next  = count_reg - 1'b1;
                end
                RD_WALK_NEXT: begin
                    walk_next = next_slot(walk_reg);
                    rem_next  = rem_reg - 1'b1;
                end
                RD_POP_FRONT: begin
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - 1'b1;
                end
                RD_POP_REAR: begin
                    tail_next  = prev_slot(tail_reg);
                    count_next = count_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg <= walk_next;
        rem_reg  <= rem_next;
        if (cmd.capture) begin
            mode_reg <= s_mode;
            key_reg  <= s_job_id;
            prio_reg <= s_job_priority;
        end
        if (cmd.out_load) begin
            status_reg   <= cmd.out_status;
            out_id_reg   <= cmd.out_use_ram ? rd_id : '0;
            out_prio_reg <= cmd.out_use_ram ? rd_prio : '0;
            last_reg     <= cmd.out_last;
        end
    end

    assign stat.mode     = mode_reg;
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.match    = (rd_id == key_reg);
    assign stat.rem_zero = (rem_reg == '0);

    assign m_status       = status_reg;
    assign m_out_job_id   = out_id_reg;
    assign m_out_priority = out_prio_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

// File: hdl/cjd_ctrl.sv
// ---------------------------------------------------------------------------
// cjd_ctrl: command sequencer for the circular job deque
// Decodes each request, steps the search and list walks one entry a cycle
// (the list walk only while the result register is free) and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module cjd_ctrl import cjd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire cjd_stat_t  stat,
    output cjd_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_LIST,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic               res_ram_reg, res_ram_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd             = '0;
        cmd.rd_sel      = RD_WALK_NEXT;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_ram_next    = res_ram_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next   = S_EMIT;
                res_ram_next = 1'b0;
                unique case (stat.mode) inside
                    MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                        if (stat.full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            res_status_next = ST_OK;
                            cmd.push_front  = (stat.mode == MODE_PUSH_FRONT);
                            cmd.push_rear   = (stat.mode == MODE_PUSH_REAR);
                        end
                    end
                    MODE_POP_FRONT, MODE_POP_REAR: begin
                        if (stat.empty) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_status_next = ST_OK;
                            res_ram_next    = 1'b1;
                            cmd.rd_en       = 1'b1;
                            cmd.rd_sel      = (stat.mode == MODE_POP_FRONT) ?
                                              RD_POP_FRONT : RD_POP_REAR;
                        end
                    end
                    MODE_SEARCH, MODE_LIST: begin
                        if (stat.empty) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_WALK_FIRST;
                            state_next = (stat.mode == MODE_SEARCH) ? S_SEARCH : S_LIST;
                        end
                    end
                    default: begin
                        // unused mode: drop the request without a result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEARCH: begin
                if (stat.match) begin
                    res_status_next = ST_OK;
                    res_ram_next    = 1'b1;
                    state_next      = S_EMIT;
                end else if (stat.rem_zero) begin
                    res_status_next = ST_NOTFOUND;
                    res_ram_next    = 1'b0;
                    state_next      = S_EMIT;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = ST_OK;
                    cmd.out_use_ram = 1'b1;
                    cmd.out_last    = stat.rem_zero;
                    if (stat.rem_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_en = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = res_status_reg;
                    cmd.out_use_ram = res_ram_reg;
                    cmd.out_last    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            res_ram_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            res_status_reg <= res_status_next;
            res_ram_reg    <= res_ram_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/circular_job_deque_top.sv
// Push, pop, and empty or full answers pass through the decode and emit states after accept.
// Search: one RAM read and compare per entry, from head toward tail, stopping at the first match.
// List: entries from head toward tail, one entry per cycle while m_ready holds.
// Requests: one request in work at a time; s_ready is high only in the idle state.
// Reset clears head, tail, count and the result valid; entry RAM is not cleared.
// ---------------------------------------------------------------------------
// circular_job_deque_top: circular double-ended job queue with search
// Push and pop at both ends, first-match search by id, and ordered list.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_job_deque_top import cjd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [MODE_W-1:0]      s_mode,
    input  wire logic [ID_W-1:0]        s_job_id,
    input  wire logic [PRIO_W-1:0]      s_job_priority,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [STAT_W-1:0]      m_status,
    output logic      [ID_W-1:0]        m_out_job_id,
    output logic      [PRIO_W-1:0]      m_out_priority,
    output logic                        m_last
);

    cjd_cmd_t  cmd;
    cjd_stat_t stat;

    cjd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cjd_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_mode         (s_mode),
        .s_job_id       (s_job_id),
        .s_job_priority (s_job_priority),
        .m_status       (m_status),
        .m_out_job_id   (m_out_job_id),
        .m_out_priority (m_out_priority),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// File: hdl/cjd_checker.sv
// ---------------------------------------------------------------------------
// cjd_checker: port-level checks for the circular job deque
// Watches the top level's handshakes and result fields over time.
// ---------------------------------------------------------------------------
`default_nettype none

module cjd_checker import cjd_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic [STAT_W-1:0]      m_status,
    input  wire logic [ID_W-1:0]        m_out_job_id,
    input  wire logic [PRIO_W-1:0]      m_out_priority,
    input  wire logic                   m_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_job_id)
            && $stable(m_out_priority) && $stable(m_last))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an accepted request leaves the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken in back-to-back cycles");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_last)
        else $error("error status not marked last");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_out_job_id == '0) && (m_out_priority == '0))
        else $error("error status carries entry fields");

endmodule

bind circular_job_deque_top cjd_checker u_cjd_checker (.*);

`default_nettype wire
